FILE: src/mmcs_pkg.sv
// Package for the min-max contrast stretch block.
// Holds widths, command codes and the sequencer state type; no dependencies.
package mmcs_pkg;

    localparam int SAMPLE_W            = 8;
    localparam int DEFAULT_MAX_SAMPLES = 4096;

    // command codes carried by the input channel
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

FILE: src/mmcs_if.sv
// Valid/ready channel interfaces for the min-max contrast stretch block.
// Depends on mmcs_pkg for the sample width.
interface mmcs_item_if
    import mmcs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                command;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output command, output sample, input ready);
    modport sink   (input valid, input command, input sample, output ready);
endinterface

interface mmcs_result_if
    import mmcs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] value;
    logic                last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

FILE: src/min_max_contrast_stretch.sv
// Min-max contrast stretch: sample store, running min/max and a serial divider.
// Depends on mmcs_pkg and the channel interfaces in mmcs_if.sv.
//
// Usage
//   items   : command = CMD_LOAD, unless the store is full, appends sample to the store and updates the
//             running min/max; CMD_DRAIN asks for the next stored sample,
//             stretched to round((v-min)*255/(max-min)).
//   results : one transaction per drain. last marks the final sample of the
//             image, after which the block clears; an empty drain returns 0, last set.
// Sequencing
//   A load is taken while idle; items.ready stays high for back-to-back loads.
//   A drain goes from acceptance to results.valid in order: the store is read
//   at the accepting edge, ST_FETCH forms the numerator, ST_DIVIDE runs the
//   one-bit-per-cycle restoring divider for eight steps, and ST_FINISH writes
//   the output register. Flat images skip ST_DIVIDE, empty drains ST_FETCH too.
//   items.ready is high only while the sequencer is idle, so no further load or
//   drain is taken until the drain in progress has written its output register.
// Reset clears count, read pointer, min (255) and max (0); the store is not
//   cleared, as only entries below the count are ever read.
// Stall: the result waits in an output register and loads are still taken;
//   a further drain computes, then waits for that register to empty.
module min_max_contrast_stretch
    import mmcs_pkg::*;
#(
    parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES
)(
    input  logic         clk,
    input  logic         rst_n,
    mmcs_item_if.sink    items,
    mmcs_result_if.source results
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int NUM_W  = 2 * SAMPLE_W + 1;   // 510*255 + 255 < 2^17

    // control state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rptr_reg, rptr_next;
    logic [SAMPLE_W-1:0] least_reg, least_next;
    logic [SAMPLE_W-1:0] greatest_reg, greatest_next;
    logic                out_valid_reg, out_valid_next;
    logic [2:0]          step_reg, step_next;

    // payload
    logic [SAMPLE_W-1:0] store_mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] rdata_reg;
    logic [SAMPLE_W:0]   rem_reg, rem_next;       // partial remainder, < 2d
    logic [SAMPLE_W-1:0] shift_reg, shift_next;   // numerator low bits in, quotient out
    logic [SAMPLE_W:0]   dvsr_reg, dvsr_next;     // 2*(max-min)
    logic [SAMPLE_W-1:0] out_value_reg, out_value_next;
    logic                out_last_reg, out_last_next;

    logic in_acc, load_acc, drain_acc, store_full;

    assign items.ready   = (state_reg == ST_IDLE);
    assign in_acc        = items.valid && items.ready;
    assign load_acc      = in_acc && (items.command == CMD_LOAD);
    assign drain_acc     = in_acc && (items.command == CMD_DRAIN);
    assign store_full    = (count_reg >= CNT_W'(MAX_SAMPLES));

    assign results.valid = out_valid_reg;
    assign results.value = out_value_reg;
    assign results.last  = out_last_reg;

    // sample store: one write port for loads, one registered read for drains
    always_ff @(posedge clk)
    begin
        if (load_acc && !store_full)
        begin
            store_mem[count_reg[ADDR_W-1:0]] <= items.sample;
        end
        if (drain_acc)
        begin
            rdata_reg <= store_mem[rptr_reg[ADDR_W-1:0]];
        end
    end

    // numerator forming
    logic                flat;
    logic [SAMPLE_W-1:0] clamped, diff, span;
    logic [NUM_W-1:0]    numer;
    // divider step
    logic [SAMPLE_W+1:0] trial;
    logic                fits;
    logic                out_free, is_last;

    always_comb
    begin
        flat    = (greatest_reg <= least_reg);
        clamped = rdata_reg;
        if (clamped < least_reg)
        begin
            clamped = least_reg;
        end
        if (clamped > greatest_reg)
        begin
            clamped = greatest_reg;
        end
        diff  = clamped - least_reg;
        span  = greatest_reg - least_reg;
        // 510*x + d, as (x << 9) - (x << 1) + d
        numer = (NUM_W'(diff) << 9) - (NUM_W'(diff) << 1) + NUM_W'(span);

        trial = {rem_reg, shift_reg[SAMPLE_W-1]};
        fits  = (trial >= {1'b0, dvsr_reg});

        out_free = !out_valid_reg || results.ready;
        is_last  = (count_reg == '0) || ((rptr_reg + CNT_W'(1)) == count_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rptr_next      = rptr_reg;
        least_next     = least_reg;
        greatest_next  = greatest_reg;
        out_valid_next = out_valid_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        shift_next     = shift_reg;
        dvsr_next      = dvsr_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_acc && !store_full)
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (items.sample < least_reg)
                    begin
                        least_next = items.sample;
                    end
                    if (items.sample > greatest_reg)
                    begin
                        greatest_next = items.sample;
                    end
                end
                if (drain_acc)
                begin
                    if (count_reg == '0)
                    begin
                        shift_next = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                if (flat)
                begin
                    shift_next = rdata_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rem_next   = numer[NUM_W-1:SAMPLE_W];
                    shift_next = numer[SAMPLE_W-1:0];
                    dvsr_next  = {span, 1'b0};
                    step_next  = 3'd7;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                rem_next   = fits ? (SAMPLE_W+1)'(trial - {1'b0, dvsr_reg})
                                  : trial[SAMPLE_W:0];
                shift_next = {shift_reg[SAMPLE_W-2:0], fits};
                step_next  = step_reg - 3'd1;
                if (step_reg == 3'd0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = shift_reg;
                    out_last_next  = is_last;
                    if (is_last)
                    begin
                        count_next    = '0;
                        rptr_next     = '0;
                        least_next    = '1;
                        greatest_next = '0;
                    end
                    else
                    begin
                        rptr_next = rptr_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rptr_reg      <= '0;
            least_reg     <= '1;
            greatest_reg  <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rptr_reg      <= rptr_next;
            least_reg     <= least_next;
            greatest_reg  <= greatest_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        shift_reg     <= shift_next;
        dvsr_reg      <= dvsr_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

endmodule

FILE: src/mmcs_checker.sv
// Port-level checks for the min-max contrast stretch block, plus the bind.
// Depends on mmcs_pkg and min_max_contrast_stretch.
module mmcs_checker
    import mmcs_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                in_command,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SAMPLE_W-1:0] out_value,
    input logic                out_last
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // pending result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    // stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(out_last))
        else $error("result payload changed while stalled");

    // a drain occupies the sequencer, so no transaction is taken next cycle
    a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (in_command == CMD_DRAIN) |=> !in_ready)
        else $error("input taken straight after a drain");

    // a load never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (in_command == CMD_LOAD) && !out_valid |=> !out_valid)
        else $error("result appeared after a load");

endmodule

bind min_max_contrast_stretch mmcs_checker u_mmcs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (items.valid),
    .in_ready   (items.ready),
    .in_command (items.command),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_value  (results.value),
    .out_last   (results.last)
);
